// ===== rtl/bnla_pkg.sv =====
// shared types and constants for the batch norm, bias and leaky activation block
`default_nettype none

package bnla_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CHANNEL_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_CHANNELS = 1024;
  localparam int DEF_STRIPE_WIDTH = 8;

  // 0.1 as a fraction of 2^16
  localparam int LEAKY_NUM = 6554;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL_SIZE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAKY_ENABLE  = 3'd4;

  typedef enum logic [1:0] {
    LK_INV_DEV = 2'd0,
    LK_MEAN    = 2'd1,
    LK_SCALE   = 2'd2,
    LK_BIAS    = 2'd3
  } load_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_A,
    ST_MUL_B,
    ST_ACT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                 load_wr;
    load_kind_t           load_kind;
    logic                 rd_en;
    logic                 diff_en;
    logic                 mul_a_en;
    logic                 mul_b_en;
    logic                 act_en;
    logic                 out_load;
    logic [CHANNEL_W-1:0] channel;
    logic                 last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/bnla_ctrl.sv =====
// controller: state machine, parameter load counters and striped channel counters
`default_nettype none

module bnla_ctrl #(
  parameter int MAX_CHANNELS = bnla_pkg::DEF_MAX_CHANNELS,
  parameter int STRIPE_WIDTH = bnla_pkg::DEF_STRIPE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_kind,
  output logic                           in_stall,
  input  logic [10:0]                    cfg_channel_count,
  input  logic [15:0]                    cfg_spatial_size,
  input  logic [8:0]                     cfg_batch_count,
  input  bnla_pkg::dp_status_t           status,
  output bnla_pkg::ctrl_cmd_t            cmd,
  output logic [$clog2(MAX_CHANNELS)-1:0] wr_addr,
  output logic [$clog2(MAX_CHANNELS)-1:0] rd_addr
);
  import bnla_pkg::*;

  localparam int AW      = $clog2(MAX_CHANNELS);
  localparam int SW_BITS = (STRIPE_WIDTH > 1) ? $clog2(STRIPE_WIDTH) : 1;
  localparam int CH_W    = 11 + SW_BITS;
  localparam logic [SW_BITS:0] SW_CNT = (SW_BITS + 1)'(STRIPE_WIDTH);

  state_t state_r, state_nxt;

  logic [1:0]         load_kind_r, load_kind_nxt;
  logic [9:0]         load_ch_r, load_ch_nxt;
  logic [SW_BITS-1:0] stripe_r, stripe_nxt;
  logic [15:0]        spatial_r, spatial_nxt;
  logic [9:0]         group_r, group_nxt;
  logic [7:0]         batch_r, batch_nxt;

  logic [10:0]   nch;
  logic [CH_W-1:0] ch;
  logic [CH_W-1:0] g_lim;
  logic          load_end, s_end, p_end, g_end, b_end;
  logic          acc_load, acc_data;

  assign nch = (cfg_channel_count == 11'd0) ? 11'd1 :
               ((32'(cfg_channel_count) > MAX_CHANNELS) ? 11'(MAX_CHANNELS) :
                cfg_channel_count);

  assign ch    = (CH_W'(group_r) * CH_W'(STRIPE_WIDTH)) + CH_W'(stripe_r);
  assign g_lim = (CH_W'(group_r) + CH_W'(1)) * CH_W'(STRIPE_WIDTH);

  assign load_end = ({1'b0, load_ch_r} + 11'd1) >= nch;
  assign s_end    = ({1'b0, stripe_r} + (SW_BITS + 1)'(1)) >= SW_CNT;
  assign p_end    = ({1'b0, spatial_r} + 17'd1) >= {1'b0, cfg_spatial_size};
  assign g_end    = g_lim >= CH_W'(nch);
  assign b_end    = ({1'b0, batch_r} + 9'd1) >= cfg_batch_count;

  assign acc_load = (state_r == ST_IDLE) && in_valid && !in_kind;
  assign acc_data = (state_r == ST_IDLE) && in_valid && in_kind;

  assign wr_addr = AW'(load_ch_r);
  assign rd_addr = AW'(ch);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (acc_data) state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MUL_A;
      ST_MUL_A: state_nxt = ST_MUL_B;
      ST_MUL_B: state_nxt = ST_ACT;
      ST_ACT:   state_nxt = ST_FIN;
      ST_FIN:   if (status.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = 1'b1;
    cmd           = '0;
    cmd.load_kind = load_kind_t'(load_kind_r);
    cmd.channel   = ch[CHANNEL_W-1:0];
    cmd.last      = s_end && p_end && g_end && b_end;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_wr = acc_load;
        cmd.rd_en   = acc_data;
      end
      ST_DIFF:  cmd.diff_en  = 1'b1;
      ST_MUL_A: cmd.mul_a_en = 1'b1;
      ST_MUL_B: cmd.mul_b_en = 1'b1;
      ST_ACT:   cmd.act_en   = 1'b1;
      ST_FIN:   cmd.out_load = status.out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // counters
  always_comb begin
    load_kind_nxt = load_kind_r;
    load_ch_nxt   = load_ch_r;
    stripe_nxt    = stripe_r;
    spatial_nxt   = spatial_r;
    group_nxt     = group_r;
    batch_nxt     = batch_r;
    if (acc_load) begin
      if (load_end) begin
        load_ch_nxt   = 10'd0;
        load_kind_nxt = load_kind_r + 2'd1;
      end else begin
        load_ch_nxt = load_ch_r + 10'd1;
      end
    end
    if (acc_data) begin
      if (!s_end) begin
        stripe_nxt = stripe_r + SW_BITS'(1);
      end else begin
        stripe_nxt = '0;
        if (!p_end) begin
          spatial_nxt = spatial_r + 16'd1;
        end else begin
          spatial_nxt = 16'd0;
          if (!g_end) begin
            group_nxt = group_r + 10'd1;
          end else begin
            group_nxt = 10'd0;
            batch_nxt = b_end ? 8'd0 : (batch_r + 8'd1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      load_kind_r <= 2'd0;
      load_ch_r   <= 10'd0;
      stripe_r    <= '0;
      spatial_r   <= 16'd0;
      group_r     <= 10'd0;
      batch_r     <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      load_kind_r <= load_kind_nxt;
      load_ch_r   <= load_ch_nxt;
      stripe_r    <= stripe_nxt;
      spatial_r   <= spatial_nxt;
      group_r     <= group_nxt;
      batch_r     <= batch_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bnla_datapath.sv =====
// datapath: parameter stores, normalize and bias arithmetic, leaky scaling, output register
`default_nettype none

module bnla_datapath #(
  parameter int MAX_CHANNELS = bnla_pkg::DEF_MAX_CHANNELS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [bnla_pkg::SAMPLE_W-1:0]  in_value,
  input  logic                                  norm_enable,
  input  logic                                  leaky_enable,
  input  bnla_pkg::ctrl_cmd_t                   cmd,
  input  logic [$clog2(MAX_CHANNELS)-1:0]       wr_addr,
  input  logic [$clog2(MAX_CHANNELS)-1:0]       rd_addr,
  output bnla_pkg::dp_status_t                  status,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bnla_pkg::SAMPLE_W-1:0]  out_result,
  output logic [bnla_pkg::CHANNEL_W-1:0]        out_channel,
  output logic                                  out_last_of_job
);
  import bnla_pkg::*;

  localparam int ACC_W = 50;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 50'sh800000;
  localparam logic [40:0] LEAKY_HALF = 41'h100_0000_0000 >> 1;

  logic [SAMPLE_W-1:0] inv_mem   [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] mean_mem  [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] scale_mem [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] bias_mem  [MAX_CHANNELS];

  logic signed [15:0]      x_r, inv_r, mean_r, scale_r, bias_r;
  logic [CHANNEL_W-1:0]    ch_r;
  logic                    last_r;
  logic signed [16:0]      diff_r, xb_r;
  logic signed [32:0]      p1_r, p1_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, acc_rnd;
  logic signed [39:0]      lq_r, lq_nxt;
  logic [40:0]             lp_r, lp_nxt;
  logic signed [25:0]      r0_r;
  logic                    sel_r;
  logic signed [40:0]      lsum;
  logic signed [25:0]      rsel;

  logic                    out_valid_r;
  logic signed [15:0]      out_result_r;
  logic [CHANNEL_W-1:0]    out_channel_r;
  logic                    out_last_r;

  function automatic logic signed [15:0] sat_q88(input logic signed [25:0] v);
    logic signed [15:0] r;
    if (v > 26'sd32767) r = 16'sh7fff;
    else if (v < -26'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // parameter stores
  always_ff @(posedge clk) begin
    if (cmd.load_wr && cmd.load_kind == LK_INV_DEV) inv_mem[wr_addr] <= in_value;
    if (cmd.rd_en) inv_r <= inv_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && cmd.load_kind == LK_MEAN) mean_mem[wr_addr] <= in_value;
    if (cmd.rd_en) mean_r <= mean_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && cmd.load_kind == LK_SCALE) scale_mem[wr_addr] <= in_value;
    if (cmd.rd_en) scale_r <= scale_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && cmd.load_kind == LK_BIAS) bias_mem[wr_addr] <= in_value;
    if (cmd.rd_en) bias_r <= bias_mem[rd_addr];
  end

  assign p1_nxt  = diff_r * inv_r;
  assign acc_nxt = norm_enable ?
                   (p1_r * scale_r + $signed({{18{bias_r[15]}}, bias_r, 16'd0})) :
                   $signed({{17{xb_r[16]}}, xb_r, 16'd0});
  assign acc_rnd = acc_r + ROUND_HALF;

  // leaky product split at bit 24 so each multiply stays narrow
  assign lq_nxt = $signed(acc_r[ACC_W-1:24]) * $signed(14'(LEAKY_NUM));
  assign lp_nxt = 41'(acc_r[23:0]) * 41'(LEAKY_NUM) + LEAKY_HALF;

  assign lsum = $signed({lq_r[39], lq_r}) + $signed({24'd0, lp_r[40:24]});
  assign rsel = sel_r ? $signed({lsum[40], lsum[40:16]}) : r0_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      x_r    <= in_value;
      ch_r   <= cmd.channel;
      last_r <= cmd.last;
    end
    if (cmd.diff_en) begin
      diff_r <= $signed({x_r[15], x_r}) - $signed({mean_r[15], mean_r});
      xb_r   <= $signed({x_r[15], x_r}) + $signed({bias_r[15], bias_r});
    end
    if (cmd.mul_a_en) p1_r <= p1_nxt;
    if (cmd.mul_b_en) acc_r <= acc_nxt;
    if (cmd.act_en) begin
      lq_r  <= lq_nxt;
      lp_r  <= lp_nxt;
      r0_r  <= acc_rnd[ACC_W-1:24];
      sel_r <= acc_r[ACC_W-1] && leaky_enable;
    end
    if (cmd.out_load) begin
      out_result_r  <= sat_q88(rsel);
      out_channel_r <= ch_r;
      out_last_r    <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;
  assign out_channel     = out_channel_r;
  assign out_last_of_job = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/batchnorm_bias_leaky_activation.sv =====
// top level: configuration registers, controller and datapath
// a load transaction is written to its parameter store when accepted; a data transaction is
// walked by the controller through the subtract, two multiply, round and saturate steps, and
// no new transaction is taken until its result has entered the output register
// a finished result waits in the output register while the next transaction is accepted
// reset clears the counters and output valid and restores the register defaults; the
// parameter stores are not cleared
`default_nettype none

module batchnorm_bias_leaky_activation #(
  parameter int MAX_CHANNELS = bnla_pkg::DEF_MAX_CHANNELS,
  parameter int STRIPE_WIDTH = bnla_pkg::DEF_STRIPE_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_kind,
  input  logic signed [bnla_pkg::SAMPLE_W-1:0]   in_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [bnla_pkg::SAMPLE_W-1:0]   out_result,
  output logic [bnla_pkg::CHANNEL_W-1:0]         out_channel,
  output logic                                   out_last_of_job,
  input  logic                                   cfg_wr_en,
  input  logic [bnla_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bnla_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import bnla_pkg::*;

  localparam int AW = $clog2(MAX_CHANNELS);

  logic [10:0] channel_count_r;
  logic [15:0] spatial_size_r;
  logic [8:0]  batch_count_r;
  logic        norm_enable_r;
  logic        leaky_enable_r;

  ctrl_cmd_t   cmd;
  dp_status_t  status;
  logic [AW-1:0] wr_addr, rd_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= 11'd1;
      spatial_size_r  <= 16'd1;
      batch_count_r   <= 9'd1;
      norm_enable_r   <= 1'b0;
      leaky_enable_r  <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[10:0];
        CFG_SPATIAL_SIZE:  spatial_size_r  <= cfg_wdata[15:0];
        CFG_BATCH_COUNT:   batch_count_r   <= cfg_wdata[8:0];
        CFG_NORM_ENABLE:   norm_enable_r   <= cfg_wdata[0];
        CFG_LEAKY_ENABLE:  leaky_enable_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  bnla_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .STRIPE_WIDTH (STRIPE_WIDTH)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_kind           (in_kind),
    .in_stall          (in_stall),
    .cfg_channel_count (channel_count_r),
    .cfg_spatial_size  (spatial_size_r),
    .cfg_batch_count   (batch_count_r),
    .status            (status),
    .cmd               (cmd),
    .wr_addr           (wr_addr),
    .rd_addr           (rd_addr)
  );

  bnla_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .norm_enable     (norm_enable_r),
    .leaky_enable    (leaky_enable_r),
    .cmd             (cmd),
    .wr_addr         (wr_addr),
    .rd_addr         (rd_addr),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result      (out_result),
    .out_channel     (out_channel),
    .out_last_of_job (out_last_of_job)
  );

endmodule

`default_nettype wire

// ===== verif/bnla_check_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard class that predicts and checks the activation block's output samples
package bnla_check_pkg;
  import bnla_pkg::*;

  localparam int NUM_CH  = DEF_MAX_CHANNELS;
  localparam int STRIPES = DEF_STRIPE_WIDTH;

  typedef struct {
    logic signed [SAMPLE_W-1:0] result;
    logic [CHANNEL_W-1:0]       channel;
    logic                       last_of_job;
  } sample_out_t;

  class activation_scoreboard;
    int errors;
    sample_out_t pending_samples[$];

    logic signed [SAMPLE_W-1:0] inv_dev_words [NUM_CH];
    logic signed [SAMPLE_W-1:0] mean_words    [NUM_CH];
    logic signed [SAMPLE_W-1:0] scale_words   [NUM_CH];
    logic signed [SAMPLE_W-1:0] bias_words    [NUM_CH];
    logic [3:0]                 word_loaded   [NUM_CH];

    load_kind_t  load_slot;
    int unsigned load_index;
    int unsigned stripe_pos, spatial_pos, group_pos, batch_pos;
    int unsigned ch_count_reg, spatial_reg, batch_reg;
    bit          norm_on, leaky_on;

    function new();
      errors = 0;
      foreach (word_loaded[i]) word_loaded[i] = 4'h0;
      load_slot    = LK_INV_DEV;
      load_index   = 0;
      stripe_pos   = 0;
      spatial_pos  = 0;
      group_pos    = 0;
      batch_pos    = 0;
      ch_count_reg = 1;
      spatial_reg  = 1;
      batch_reg    = 1;
      norm_on      = 1'b0;
      leaky_on     = 1'b1;
    endfunction

    function int unsigned eff_channels();
      if (ch_count_reg == 0) return 1;
      if (ch_count_reg > NUM_CH) return NUM_CH;
      return ch_count_reg;
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction

    function bit load_aligned();
      return (load_slot == LK_INV_DEV) && (load_index == 0);
    endfunction

    // true when this sample and the one after it read fully loaded channels
    function bit safe_to_sample();
      int unsigned s, p, g;
      s = stripe_pos;
      p = spatial_pos;
      g = group_pos;
      if (word_loaded[(g * STRIPES + s) & (NUM_CH - 1)] != 4'hF) return 1'b0;
      if (s + 1 < STRIPES) begin
        s++;
      end else begin
        s = 0;
        if (p + 1 < spatial_reg) begin
          p = (p + 1) & 'hFFFF;
        end else if ((g + 1) * STRIPES < eff_channels()) begin
          g = (g + 1) & 'h3FF;
        end else begin
          g = 0;
        end
      end
      return word_loaded[(g * STRIPES + s) & (NUM_CH - 1)] == 4'hF;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHANNEL_COUNT: ch_count_reg = data & 16'h07FF;
        CFG_SPATIAL_SIZE:  spatial_reg  = data;
        CFG_BATCH_COUNT:   batch_reg    = data & 16'h01FF;
        CFG_NORM_ENABLE:   norm_on      = data[0];
        CFG_LEAKY_ENABLE:  leaky_on     = data[0];
        default: ;
      endcase
    endfunction

    function sample_out_t predict_sample(logic signed [SAMPLE_W-1:0] x_in);
      sample_out_t e;
      int unsigned ch, a;
      longint      x, acc, r;
      bit          s_end, p_end, g_end, b_end;
      ch = group_pos * STRIPES + stripe_pos;
      a  = ch & (NUM_CH - 1);
      x  = x_in;
      if (norm_on)
        acc = (x - longint'(mean_words[a])) * longint'(inv_dev_words[a])
              * longint'(scale_words[a]) + longint'(bias_words[a]) * 65536;
      else
        acc = (x + longint'(bias_words[a])) * 65536;
      if (acc < 0 && leaky_on)
        r = (acc * LEAKY_NUM + (longint'(1) <<< 39)) >>> 40;
      else
        r = (acc + (longint'(1) <<< 23)) >>> 24;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;

      s_end = stripe_pos + 1 >= STRIPES;
      p_end = spatial_pos + 1 >= spatial_reg;
      g_end = (group_pos + 1) * STRIPES >= eff_channels();
      b_end = batch_pos + 1 >= batch_reg;

      e.result      = r[SAMPLE_W-1:0];
      e.channel     = ch[CHANNEL_W-1:0];
      e.last_of_job = s_end && p_end && g_end && b_end;

      if (!s_end) begin
        stripe_pos++;
      end else begin
        stripe_pos = 0;
        if (!p_end) begin
          spatial_pos = (spatial_pos + 1) & 'hFFFF;
        end else begin
          spatial_pos = 0;
          if (!g_end) begin
            group_pos = (group_pos + 1) & 'h3FF;
          end else begin
            group_pos = 0;
            batch_pos = b_end ? 0 : ((batch_pos + 1) & 'hFF);
          end
        end
      end
      return e;
    endfunction

    function void note_input(logic kind, logic signed [SAMPLE_W-1:0] value);
      int unsigned a;
      logic [1:0]  next_slot;
      if (kind) begin
        pending_samples.push_back(predict_sample(value));
        return;
      end
      a = load_index & (NUM_CH - 1);
      case (load_slot)
        LK_INV_DEV: inv_dev_words[a] = value;
        LK_MEAN:    mean_words[a]    = value;
        LK_SCALE:   scale_words[a]   = value;
        default:    bias_words[a]    = value;
      endcase
      word_loaded[a][int'(load_slot)] = 1'b1;
      if (load_index + 1 >= eff_channels()) begin
        load_index = 0;
        next_slot  = load_slot + 2'd1;
        load_slot  = load_kind_t'(next_slot);
      end else begin
        load_index = (load_index + 1) & 'h3FF;
      end
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(logic signed [SAMPLE_W-1:0] res, logic [CHANNEL_W-1:0] chan,
                      logic last);
      sample_out_t e;
      if (pending_samples.size() == 0) begin
        report($sformatf("unexpected transaction, result %0d channel %0d", res, chan));
        return;
      end
      e = pending_samples.pop_front();
      if (res !== e.result)
        report($sformatf("result %0d, want %0d (channel %0d)", res, e.result, e.channel));
      if (chan !== e.channel)
        report($sformatf("channel %0d, want %0d", chan, e.channel));
      if (last !== e.last_of_job)
        report($sformatf("last_of_job %0b, want %0b (channel %0d)", last, e.last_of_job,
                         e.channel));
    endtask

    task finish_check();
      if (pending_samples.size() != 0)
        report($sformatf("%0d expected transactions never arrived", pending_samples.size()));
    endtask
  endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// top-level testbench for the batch norm, bias and leaky activation block
module tb_top;
  import bnla_pkg::*;
  import bnla_check_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int TARGET_ITEMS   = 1800;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_kind;
  logic signed [SAMPLE_W-1:0] in_value;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_result;
  logic [CHANNEL_W-1:0]       out_channel;
  logic                       out_last_of_job;
  logic                       cfg_wr_en;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;

  int  send_idle_pct;
  int  recv_idle_pct;
  int  items_sent;
  int  hold_left;
  int  quiet_cycles;
  bit  hold_req;
  activation_scoreboard sb;

  batchnorm_bias_leaky_activation i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result      (out_result),
    .out_channel     (out_channel),
    .out_last_of_job (out_last_of_job),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_kind, in_value);
      if (out_valid && !out_stall) sb.check_result(out_result, out_channel, out_last_of_job);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_word();
    case ($urandom_range(3))
      0: return SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      default: return SAMPLE_W'($urandom_range(1023)) - 16'sd512;
    endcase
  endfunction

  // register value with random junk above the register width now and then
  function automatic logic [CFG_DATA_W-1:0] reg_word(int value, int width);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'(value);
    if (width < CFG_DATA_W && $urandom_range(3) == 0) w |= CFG_DATA_W'($urandom) << width;
    return w;
  endfunction

  task automatic send_item(logic kind, logic signed [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic write_config(int cc, int ss, int bc, bit ne, bit le);
    put_reg(CFG_CHANNEL_COUNT, reg_word(cc, 11));
    put_reg(CFG_SPATIAL_SIZE, reg_word(ss, 16));
    put_reg(CFG_BATCH_COUNT, reg_word(bc, 9));
    put_reg(CFG_NORM_ENABLE, reg_word(ne, 1));
    put_reg(CFG_LEAKY_ENABLE, reg_word(le, 1));
    if ($urandom_range(4) == 0) put_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // finish any partial parameter set, then load a complete one
  task automatic reload_params();
    int n;
    while (!sb.load_aligned()) send_item(1'b0, rand_word());
    n = 4 * sb.eff_channels();
    repeat (n) send_item(1'b0, rand_word());
  endtask

  initial begin
    int  cc, ss, bc, n, phase;
    bit  ne, le, pressed;
    logic signed [SAMPLE_W-1:0] dir_params [32] = '{
      16'sd256, 16'sd32767, -16'sd32768, 16'sd256, 16'sd1, 16'sd0, -16'sd256, 16'sd512,
      16'sd0, -16'sd32768, 16'sd32767, 16'sd128, 16'sd0, -16'sd1, 16'sd256, 16'sd0,
      16'sd256, 16'sd32767, 16'sd32767, -16'sd256, 16'sd256, 16'sd0, 16'sd256, -16'sd32768,
      16'sd0, 16'sd32767, -16'sd32768, -16'sd1, 16'sd1, 16'sd0, 16'sd256, 16'sd100};
    logic signed [SAMPLE_W-1:0] dir_samples [8] = '{
      16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1, 16'sd256, -16'sd256, 16'sd32767};

    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = 1'b0;
    in_value      = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    send_idle_pct = 27;
    recv_idle_pct = 82;
    items_sent    = 0;
    pressed       = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extreme parameters on eight channels, two batches with norm and leaky
    write_config(8, 1, 2, 1'b1, 1'b1);
    foreach (dir_params[i]) send_item(1'b0, dir_params[i]);
    for (int i = 0; i < 16; i++)
      send_item(1'b1, (i < 8) ? dir_samples[i] : ~dir_samples[i - 8]);
    wait_idle();
    write_config(8, 1, 1, 1'b0, 1'b0);
    foreach (dir_samples[i]) send_item(1'b1, dir_samples[i]);

    // load the first 64 channels; the kind counter wraps back to the first kind at the end
    wait_idle();
    write_config(64, 1, 1, 1'b1, 1'b1);
    reload_params();

    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent < 600) begin
        send_idle_pct = 27;
        recv_idle_pct = 82;
      end else if (items_sent < 1200) begin
        send_idle_pct = 82;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (phase)
        0: begin cc = 1024; ss = 65535; bc = 256; end
        1: begin cc = 0;    ss = 0;     bc = 0;   end
        2: begin cc = 2047; ss = 1;     bc = 511; end
        3: begin cc = 13;   ss = 2;     bc = 1;   end
        default: begin
          cc = $urandom_range(1) ? 8 * $urandom_range(1, 8) : $urandom_range(1, 64);
          case ($urandom_range(9))
            0: ss = $urandom_range(65535);
            1: ss = 0;
            default: ss = $urandom_range(1, 4);
          endcase
          case ($urandom_range(9))
            0: bc = $urandom_range(511);
            1: bc = 0;
            default: bc = $urandom_range(1, 3);
          endcase
        end
      endcase
      ne = $urandom_range(1);
      le = $urandom_range(1);
      n  = $urandom_range(20, 120);
      if (!pressed && items_sent >= 1200) begin
        cc = 16;
        ss = 2;
        bc = 2;
        n  = 80;
      end

      wait_idle();
      write_config(cc, ss, bc, ne, le);
      if (!pressed && items_sent >= 1200) begin
        pressed  = 1'b1;
        hold_req = 1'b1;
      end
      if (sb.eff_channels() <= 64 && (phase == 3 || $urandom_range(2) == 0)) reload_params();

      for (int i = 0; i < n; i++) begin
        if ($urandom_range(19) == 0) begin
          send_item(1'b0, rand_word());
        end else if (sb.safe_to_sample()) begin
          send_item(1'b1, rand_word());
        end else begin
          break;
        end
      end
      phase++;
    end

    wait_idle();
    sb.finish_check();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
